>>> design/arp_pkg.sv
// Shared constants, codes and types of the ARP cache block.
// No dependencies; every other file of the block except arp_ifs imports this package.
package arp_pkg;

   localparam int TABLE_ENTRIES = 32;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   localparam int MIN_FRAME_BYTES = 42;
   localparam logic [15:0] OP_REQUEST = 16'd1;

   localparam logic MODE_PACKET = 1'b0;
   localparam logic MODE_LOOKUP = 1'b1;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_SHORT = 2'd1;
   localparam logic [1:0] ST_MISS  = 2'd2;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_IP  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_MAC = 2'd1;

   typedef struct packed {
      logic        mode;
      logic [10:0] frame_length;
      logic [15:0] arp_opcode;
      logic [31:0] src_ip;
      logic [47:0] src_mac;
      logic [31:0] tgt_ip;
      logic [31:0] lookup_ip;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        send_reply;
      logic [47:0] reply_dest_mac;
      logic [31:0] reply_dest_ip;
      logic [47:0] found_mac;
   } rsp_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic [31:0]      ip;
      logic [47:0]      mac;
   } tbl_wr_type;

endpackage

>>> design/arp_ifs.sv
// Valid/ready channel interfaces for the request and response items.
// Depends on nothing; the field widths follow the block's item layout.
interface arp_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [10:0] frame_length;
   logic [15:0] arp_opcode;
   logic [31:0] src_ip;
   logic [47:0] src_mac;
   logic [31:0] tgt_ip;
   logic [31:0] lookup_ip;

   modport source (output valid, mode, frame_length, arp_opcode, src_ip, src_mac,
                   tgt_ip, lookup_ip, input ready);
   modport sink (input valid, mode, frame_length, arp_opcode, src_ip, src_mac,
                 tgt_ip, lookup_ip, output ready);
endinterface

interface arp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic        send_reply;
   logic [47:0] reply_dest_mac;
   logic [31:0] reply_dest_ip;
   logic [47:0] found_mac;

   modport source (output valid, status, send_reply, reply_dest_mac, reply_dest_ip,
                   found_mac, input ready);
   modport sink (input valid, status, send_reply, reply_dest_mac, reply_dest_ip,
                 found_mac, output ready);
endinterface

>>> design/arp_cache_learn_and_reply.sv
// Top level of the ARP cache with reply decision.
// Depends on arp_pkg, arp_ifs (channel interfaces) and arp_ctrl.
//
// The block keeps a table of up to TABLE_ENTRIES sender IP/MAC pairs learned from
// received ARP packets and answers cache lookups. A packet item (mode 0) shorter than
// 42 bytes is rejected with status 1 and changes nothing. Otherwise the sender IP is
// searched; a known sender has its MAC refreshed, a new one is appended while there is
// room, and a full table ignores new senders since nothing is ever evicted. A request
// whose target IP equals own_ip raises send_reply with the requester's MAC and IP; the
// reply frame itself is built elsewhere, which is also where own_mac is consumed, so
// this block takes writes to that register without storing it. A lookup item (mode 1)
// returns the cached MAC with status 0, or status 2 on a miss. Each item gives exactly
// one response item. Items are handled one at a time: the table has a single read
// port and the search reads one entry per cycle through one comparator, stopping at
// the first matching entry or after all filled entries have been read; a short frame
// skips the search. A finished response sits in an output register, so the next
// item may be taken while it waits for the sink; if that register is still occupied
// when the next response is ready, the item holds in its last cycle until the sink
// takes the older one. The table needs no clearing after reset: a fill count marks
// which entries are valid.
module arp_cache_learn_and_reply
   import arp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   arp_req_if.sink              req,
   arp_rsp_if.source            rsp,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [47:0]          csr_wdata
);

   logic [31:0] own_ip_ff;
   req_type     req_item;
   rsp_type     rsp_item;

   // Only own_ip is held here; writes to own_mac and to unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         own_ip_ff <= '0;
      end else if (csr_we && (csr_index == CSR_OWN_IP)) begin
         own_ip_ff <= csr_wdata[31:0];
      end
   end

   assign req_item.mode         = req.mode;
   assign req_item.frame_length = req.frame_length;
   assign req_item.arp_opcode   = req.arp_opcode;
   assign req_item.src_ip       = req.src_ip;
   assign req_item.src_mac      = req.src_mac;
   assign req_item.tgt_ip       = req.tgt_ip;
   assign req_item.lookup_ip    = req.lookup_ip;

   arp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .req_item  (req_item),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .rsp_item  (rsp_item),
      .own_ip    (own_ip_ff)
   );

   assign rsp.status         = rsp_item.status;
   assign rsp.send_reply     = rsp_item.send_reply;
   assign rsp.reply_dest_mac = rsp_item.reply_dest_mac;
   assign rsp.reply_dest_ip  = rsp_item.reply_dest_ip;
   assign rsp.found_mac      = rsp_item.found_mac;

   // An own_mac write is recognized but has no effect inside this block.
   a_own_ip_hold: assert property (@(posedge clock) disable iff (reset)
      csr_we && (csr_index == CSR_OWN_MAC) |=> $stable(own_ip_ff))
      else $error("own_mac write disturbed own_ip");

   a_own_ip_load: assert property (@(posedge clock) disable iff (reset)
      csr_we && (csr_index == CSR_OWN_IP) |=> own_ip_ff == $past(csr_wdata[31:0]))
      else $error("own_ip write lost");

   a_idle_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) |-> $past(!req.ready))
      else $error("response posted without an item in progress");

endmodule

>>> design/arp_table.sv
// IP/MAC entry memory of the ARP cache: one write port, one registered read port.
// Depends on arp_pkg.
module arp_entry_mem
   import arp_pkg::*;
(
   input  logic             clock,
   input  tbl_wr_type       wr,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [31:0]      rd_ip,
   output logic [47:0]      rd_mac
);

   logic [31:0] ip_mem [TABLE_ENTRIES];
   logic [47:0] mac_mem [TABLE_ENTRIES];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         ip_mem[wr.addr]  <= wr.ip;
         mac_mem[wr.addr] <= wr.mac;
      end
      rd_ip  <= ip_mem[rd_addr];
      rd_mac <= mac_mem[rd_addr];
   end

endmodule

>>> design/arp_ctrl.sv
// Sequencer of the ARP cache: scans the table with one shared comparator,
// updates it and builds the response. Depends on arp_pkg and arp_entry_mem.
module arp_ctrl
   import arp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_item,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_item,
   input  logic [31:0] own_ip
);

   typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_DONE} state_type;

   state_type        state_ff, state_in;
   req_type          item_ff, item_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic             pend_vld_ff, pend_vld_in;
   logic [IDX_W-1:0] pend_idx_ff, pend_idx_in;
   logic [1:0]       status_ff, status_in;
   logic [47:0]      found_ff, found_in;
   logic             out_vld_ff, out_vld_in;
   rsp_type          out_ff, out_in;

   tbl_wr_type       tbl_wr;
   logic [31:0]      rd_ip;
   logic [47:0]      rd_mac;
   logic [31:0]      key;
   logic             issue;
   logic             hit;
   logic             miss;
   logic             reply;

   arp_entry_mem u_table (
      .clock   (clock),
      .wr      (tbl_wr),
      .rd_addr (rd_idx_ff[IDX_W-1:0]),
      .rd_ip   (rd_ip),
      .rd_mac  (rd_mac)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = out_vld_ff;
   assign rsp_item  = out_ff;

   always_comb begin
      key   = (item_ff.mode == MODE_LOOKUP) ? item_ff.lookup_ip : item_ff.src_ip;
      issue = (rd_idx_ff < count_ff);
      hit   = pend_vld_ff && (rd_ip == key);
      miss  = !pend_vld_ff && !issue;
      reply = (item_ff.mode == MODE_PACKET) && (status_ff == ST_OK)
              && (item_ff.arp_opcode == OP_REQUEST) && (item_ff.tgt_ip == own_ip);

      state_in    = state_ff;
      item_in     = item_ff;
      count_in    = count_ff;
      rd_idx_in   = rd_idx_ff;
      pend_vld_in = pend_vld_ff;
      pend_idx_in = pend_idx_ff;
      status_in   = status_ff;
      found_in    = found_ff;
      out_vld_in  = out_vld_ff && !rsp_ready;
      out_in      = out_ff;
      tbl_wr.en   = 1'b0;
      tbl_wr.addr = pend_idx_ff;
      tbl_wr.ip   = item_ff.src_ip;
      tbl_wr.mac  = item_ff.src_mac;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in     = req_item;
               rd_idx_in   = '0;
               pend_vld_in = 1'b0;
               status_in   = ST_OK;
               found_in    = '0;
               if ((req_item.mode == MODE_PACKET)
                   && (req_item.frame_length < 11'(MIN_FRAME_BYTES))) begin
                  status_in = ST_SHORT;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_SEARCH;
               end
            end
         end
         S_SEARCH: begin
            if (hit || miss) begin
               state_in = S_DONE;
               if (item_ff.mode == MODE_LOOKUP) begin
                  if (hit) begin
                     found_in = rd_mac;
                  end else begin
                     status_in = ST_MISS;
                  end
               end else if (hit) begin
                  tbl_wr.en = 1'b1;
               end else if (count_ff < CNT_W'(TABLE_ENTRIES)) begin
                  // Append the new sender in the first free slot.
                  tbl_wr.en   = 1'b1;
                  tbl_wr.addr = count_ff[IDX_W-1:0];
                  count_in    = count_ff + 1'b1;
               end
            end else begin
               rd_idx_in   = rd_idx_ff + CNT_W'(issue);
               pend_vld_in = issue;
               pend_idx_in = rd_idx_ff[IDX_W-1:0];
            end
         end
         S_DONE: begin
            if (!out_vld_ff || rsp_ready) begin
               out_vld_in            = 1'b1;
               out_in.status         = status_ff;
               out_in.send_reply     = reply;
               out_in.reply_dest_mac = reply ? item_ff.src_mac : 48'd0;
               out_in.reply_dest_ip  = reply ? item_ff.src_ip : 32'd0;
               out_in.found_mac      = found_ff;
               state_in              = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         out_vld_ff <= out_vld_in;
      end
      item_ff     <= item_in;
      rd_idx_ff   <= rd_idx_in;
      pend_vld_ff <= pend_vld_in;
      pend_idx_ff <= pend_idx_in;
      status_ff   <= status_in;
      found_ff    <= found_in;
      out_ff      <= out_in;
   end

   // The fill count never passes the table size.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_ENTRIES))
      else $error("entry count beyond table size");

   // A write at the fill position is an append and grows the count by one.
   a_append_count: assert property (@(posedge clock) disable iff (reset)
      tbl_wr.en && (CNT_W'(tbl_wr.addr) == count_ff)
      |=> count_ff == $past(count_ff) + 1'b1)
      else $error("append did not advance entry count");

   // Only a successful packet can ask for a reply.
   a_reply_ok: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && out_ff.send_reply |-> out_ff.status == ST_OK)
      else $error("reply raised with error status");

   // A search only ever ends in the posting state.
   a_search_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SEARCH |=> state_ff == S_SEARCH || state_ff == S_DONE)
      else $error("search left without posting a result");

endmodule

>>> verif/arp_tb_pkg.sv
// Response predictor and checker for the ARP cache testbench.
// Depends on arp_pkg for the item types, the table size and the status codes.
package arp_tb_pkg;
   import arp_pkg::*;

   class arp_reply_tracker;
      logic [31:0] cached_ip [TABLE_ENTRIES];
      logic [47:0] cached_mac [TABLE_ENTRIES];
      int unsigned fill_count;
      logic [31:0] own_ip;
      rsp_type     due_responses [$];
      int unsigned mismatch_count;

      function new();
         fill_count     = 0;
         own_ip         = '0;
         mismatch_count = 0;
      endfunction

      // Only own_ip reaches a response; own_mac and spare indexes leave no trace.
      function void write_register(logic [CSR_IDX_W-1:0] index, logic [47:0] value);
         if (index == CSR_OWN_IP) begin
            own_ip = value[31:0];
         end
      endfunction

      function int find_ip(logic [31:0] ip);
         for (int i = 0; i < fill_count; i++) begin
            if (cached_ip[i] == ip) begin
               return i;
            end
         end
         return -1;
      endfunction

      // Updates the cache copy for one accepted item and queues its response.
      function void note_request(req_type it);
         rsp_type want;
         int      slot;
         want        = '0;
         want.status = ST_OK;
         if (it.mode == MODE_LOOKUP) begin
            slot = find_ip(it.lookup_ip);
            if (slot >= 0) begin
               want.found_mac = cached_mac[slot];
            end else begin
               want.status = ST_MISS;
            end
         end else if (it.frame_length < MIN_FRAME_BYTES) begin
            want.status = ST_SHORT;
         end else begin
            slot = find_ip(it.src_ip);
            if (slot >= 0) begin
               cached_mac[slot] = it.src_mac;
            end else if (fill_count < TABLE_ENTRIES) begin
               cached_ip[fill_count]  = it.src_ip;
               cached_mac[fill_count] = it.src_mac;
               fill_count++;
            end
            if (it.arp_opcode == OP_REQUEST && it.tgt_ip == own_ip) begin
               want.send_reply     = 1'b1;
               want.reply_dest_mac = it.src_mac;
               want.reply_dest_ip  = it.src_ip;
            end
         end
         due_responses.push_back(want);
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH: %s", msg);
         mismatch_count++;
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (due_responses.size() == 0) begin
            report_mismatch("response item arrived with none outstanding");
            return;
         end
         want = due_responses.pop_front();
         if (got.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
         if (got.send_reply !== want.send_reply)
            report_mismatch($sformatf("send_reply got %0b want %0b",
                                      got.send_reply, want.send_reply));
         if (got.reply_dest_mac !== want.reply_dest_mac)
            report_mismatch($sformatf("reply_dest_mac got %h want %h",
                                      got.reply_dest_mac, want.reply_dest_mac));
         if (got.reply_dest_ip !== want.reply_dest_ip)
            report_mismatch($sformatf("reply_dest_ip got %h want %h",
                                      got.reply_dest_ip, want.reply_dest_ip));
         if (got.found_mac !== want.found_mac)
            report_mismatch($sformatf("found_mac got %h want %h",
                                      got.found_mac, want.found_mac));
      endtask
   endclass

endpackage

>>> verif/tb_arp_cache_learn_and_reply.sv
// Top-level testbench of the ARP cache with reply decision.
// Depends on arp_pkg, the channel interfaces in arp_ifs and arp_tb_pkg (the tracker).
module tb_arp_cache_learn_and_reply;
   import arp_pkg::*;
   import arp_tb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // The search reads one entry per cycle, so an item on a full table takes longest;
   // settling waits long enough for such a search to finish.
   localparam int          SETTLE_CYCLES = TABLE_ENTRIES + 8;
   localparam int          CYCLE_LIMIT   = 1_000_000;
   localparam int          PHASES        = 6;
   localparam int          PHASE_ITEMS   = 270;
   localparam int          POOL_SIZE     = 48;
   localparam int          HOLD_CYCLES   = 400;
   localparam logic [15:0] OP_REPLY      = 16'd2;

   // Register indexes past own_mac; writes there must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = CSR_OWN_MAC + 1'b1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = CSR_OWN_MAC + 2'd2;

   // Pacing styles of the response sink.
   localparam int SINK_STEADY = 0;
   localparam int SINK_COIN   = 1;
   localparam int SINK_SPARSE = 2;
   localparam int SINK_BURSTY = 3;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [47:0]          csr_wdata;

   arp_req_if req_ch ();
   arp_rsp_if rsp_ch ();

   arp_cache_learn_and_reply u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   arp_reply_tracker tracker = new;

   logic [31:0] ip_pool [POOL_SIZE];
   int unsigned burst_left;
   int unsigned hold_requests;
   int unsigned cycle_count = 0;

   always #1 clock = ~clock;

   // Watchdog: a run that stalls or loses a response ends here as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_arp_cache_learn_and_reply failed");
         $finish;
      end
   end

   // Every accepted request item goes to the tracker, which predicts its response.
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         tracker.note_request(req_type'{mode: req_ch.mode,
                                        frame_length: req_ch.frame_length,
                                        arp_opcode: req_ch.arp_opcode,
                                        src_ip: req_ch.src_ip,
                                        src_mac: req_ch.src_mac,
                                        tgt_ip: req_ch.tgt_ip,
                                        lookup_ip: req_ch.lookup_ip});
      end
   end

   // Every accepted response item is compared with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         tracker.check_response(rsp_type'{status: rsp_ch.status,
                                          send_reply: rsp_ch.send_reply,
                                          reply_dest_mac: rsp_ch.reply_dest_mac,
                                          reply_dest_ip: rsp_ch.reply_dest_ip,
                                          found_mac: rsp_ch.found_mac});
      end
   end

   // Response sink. It switches between pacing styles at random intervals. When the
   // stimulus asks for a long hold (by bumping hold_requests), it drops ready until the
   // hold counter, loaded from HOLD_CYCLES, runs out, while the source keeps offering items; the
   // output register and the item in flight fill up and the block must stall its input.
   initial begin : response_sink
      int unsigned style;
      int unsigned phase_left;
      int unsigned hold_left;
      int unsigned holds_served;
      style        = SINK_STEADY;
      phase_left   = 0;
      hold_left    = 0;
      holds_served = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            if (phase_left == 0) begin
               style      = $urandom_range(SINK_STEADY, SINK_BURSTY);
               phase_left = $urandom_range(10, 150);
            end
            phase_left--;
            case (style)
               SINK_STEADY: rsp_ch.ready <= 1'b1;
               SINK_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
               SINK_SPARSE: rsp_ch.ready <= ($urandom_range(0, 4) == 0);
               default:     rsp_ch.ready <= ((phase_left % 8) < 4);
            endcase
         end
      end
   end

   // Offers one item and returns at the edge where it was accepted. The source works
   // in bursts: at the start of each burst it may drop valid for a random gap, and
   // within a burst valid stays high from item to item.
   task automatic offer_item(input req_type it);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap        = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid        <= 1'b1;
      req_ch.mode         <= it.mode;
      req_ch.frame_length <= it.frame_length;
      req_ch.arp_opcode   <= it.arp_opcode;
      req_ch.src_ip       <= it.src_ip;
      req_ch.src_mac      <= it.src_mac;
      req_ch.tgt_ip       <= it.tgt_ip;
      req_ch.lookup_ip    <= it.lookup_ip;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Stops offering until every predicted response has come back, then lets the
   // block run out any search that might still be going on. The first edge makes
   // sure the item accepted just before has been recorded by the tracker.
   task automatic settle();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (tracker.due_responses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes both registers back to back, and optionally the two spare indexes, which
   // must be ignored. The upper bits of an own_ip write carry noise on purpose.
   task automatic configure(input logic [31:0] ip, input logic [47:0] mac,
                            input bit poke_spare);
      csr_we    <= 1'b1;
      csr_index <= CSR_OWN_IP;
      csr_wdata <= {16'($urandom), ip};
      @(posedge clock);
      tracker.write_register(CSR_OWN_IP, {16'd0, ip});
      csr_index <= CSR_OWN_MAC;
      csr_wdata <= mac;
      @(posedge clock);
      tracker.write_register(CSR_OWN_MAC, mac);
      if (poke_spare) begin
         csr_index <= CSR_SPARE_LO;
         csr_wdata <= {16'($urandom), $urandom};
         @(posedge clock);
         csr_index <= CSR_SPARE_HI;
         csr_wdata <= {16'($urandom), $urandom};
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // A packet item; the lookup field is irrelevant in packet mode and is left random.
   function automatic req_type packet_item(input logic [10:0] len, input logic [15:0] op,
                                           input logic [31:0] sip, input logic [47:0] smac,
                                           input logic [31:0] tip);
      req_type it;
      it.mode         = MODE_PACKET;
      it.frame_length = len;
      it.arp_opcode   = op;
      it.src_ip       = sip;
      it.src_mac      = smac;
      it.tgt_ip       = tip;
      it.lookup_ip    = $urandom;
      return it;
   endfunction

   // A lookup item; all packet fields are random and must have no effect.
   function automatic req_type lookup_item(input logic [31:0] ip);
      req_type it;
      it              = packet_item(11'($urandom), 16'($urandom), $urandom,
                                    {16'($urandom), $urandom}, $urandom);
      it.mode         = MODE_LOOKUP;
      it.lookup_ip    = ip;
      return it;
   endfunction

   // Random item. Sender and lookup addresses come mostly from the first `span`
   // pool entries so that hits, MAC refreshes and the full table all show up; the
   // target often equals own_ip, or misses it by a single bit.
   function automatic req_type random_item(input int unsigned span);
      req_type     it;
      int unsigned pick;
      it.mode = 1'($urandom_range(0, 1));
      pick    = $urandom_range(0, 99);
      if (pick < 12)      it.frame_length = 11'($urandom_range(0, MIN_FRAME_BYTES - 1));
      else if (pick < 16) it.frame_length = 11'(MIN_FRAME_BYTES);
      else if (pick < 19) it.frame_length = 11'h7FF;
      else if (pick < 22) it.frame_length = 11'(MIN_FRAME_BYTES - 1);
      else                it.frame_length = 11'($urandom_range(MIN_FRAME_BYTES, 2047));
      pick = $urandom_range(0, 99);
      if (pick < 50)      it.arp_opcode = OP_REQUEST;
      else if (pick < 70) it.arp_opcode = OP_REPLY;
      else                it.arp_opcode = 16'($urandom_range(0, 65535));
      it.src_ip  = ($urandom_range(0, 99) < 85) ? ip_pool[$urandom_range(0, span - 1)]
                                                : $urandom;
      it.src_mac = {16'($urandom), $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 45)      it.tgt_ip = tracker.own_ip;
      else if (pick < 55) it.tgt_ip = tracker.own_ip ^ (32'd1 << $urandom_range(0, 31));
      else if (pick < 75) it.tgt_ip = ip_pool[$urandom_range(0, span - 1)];
      else                it.tgt_ip = $urandom;
      it.lookup_ip = ($urandom_range(0, 99) < 80) ? ip_pool[$urandom_range(0, span - 1)]
                                                  : $urandom;
      return it;
   endfunction

   initial begin : stimulus
      logic [31:0] phase_ip;
      logic [47:0] phase_mac;
      int unsigned span;
      req_ch.valid        = 1'b0;
      req_ch.mode         = MODE_PACKET;
      req_ch.frame_length = '0;
      req_ch.arp_opcode   = '0;
      req_ch.src_ip       = '0;
      req_ch.src_mac      = '0;
      req_ch.tgt_ip       = '0;
      req_ch.lookup_ip    = '0;
      csr_we              = 1'b0;
      csr_index           = CSR_OWN_IP;
      csr_wdata           = '0;
      burst_left          = 0;
      hold_requests       = 0;
      ip_pool[0] = 32'h0000_0000;
      ip_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < POOL_SIZE; i++) ip_pool[i] = $urandom;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, first with own_ip at its reset value of zero.
      // A lookup on the empty table must miss.
      offer_item(lookup_item(32'h0000_0000));
      // Short frames are rejected even when they carry a request to us.
      offer_item(packet_item(11'd0, OP_REQUEST, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'd0));
      offer_item(packet_item(11'(MIN_FRAME_BYTES - 1), OP_REQUEST, 32'd0,
                             48'h1234_5678_9ABC, 32'd0));
      offer_item(lookup_item(32'hFFFF_FFFF));
      // Shortest accepted frame: learned, and a request to own_ip gets a reply.
      offer_item(packet_item(11'(MIN_FRAME_BYTES), OP_REQUEST, 32'd0, 48'hFFFF_FFFF_FFFF,
                             32'd0));
      offer_item(lookup_item(32'h0000_0000));
      // Longest frame with a reply opcode: learned only, never answered.
      offer_item(packet_item(11'h7FF, OP_REPLY, 32'hFFFF_FFFF, 48'd0, 32'd0));
      offer_item(lookup_item(32'hFFFF_FFFF));
      // Unknown opcodes are learned from; a known sender gets its MAC refreshed.
      offer_item(packet_item(11'd60, 16'hFFFF, 32'd0, 48'h0A0B_0C0D_0E0F, 32'd0));
      offer_item(lookup_item(32'h0000_0000));
      offer_item(packet_item(11'd60, 16'h0000, ip_pool[2], {16'($urandom), $urandom},
                             32'd0));
      // A request aimed elsewhere gets no reply.
      offer_item(packet_item(11'd64, OP_REQUEST, ip_pool[3], 48'h8000_0000_0001,
                             32'hFFFF_FFFF));
      offer_item(lookup_item(ip_pool[3]));
      offer_item(lookup_item($urandom));

      // Register writes happen only with the block idle.
      settle();
      configure(32'hC0A8_0001, 48'h0200_0000_0001, 1'b1);
      offer_item(packet_item(11'd42, OP_REQUEST, ip_pool[4], 48'h5555_AAAA_5555,
                             32'hC0A8_0001));
      offer_item(packet_item(11'd42, OP_REQUEST, ip_pool[5], 48'hAAAA_5555_AAAA,
                             32'hC0A8_0000));
      offer_item(packet_item(11'd100, OP_REQUEST, 32'd0, 48'h0000_0000_0001,
                             32'hC0A8_0001));
      offer_item(lookup_item(ip_pool[4]));
      offer_item(lookup_item(32'd0));

      // Random phases with a fresh register setting each; the address pool widens
      // after the first phase so the table fills part way first, then completely,
      // after which new senders are dropped while known ones still refresh.
      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         case (phase)
            0:       begin phase_ip = 32'hFFFF_FFFF; phase_mac = 48'hFFFF_FFFF_FFFF; end
            1:       begin phase_ip = 32'h0000_0000; phase_mac = 48'h0000_0000_0000; end
            3:       begin phase_ip = ip_pool[3];    phase_mac = {16'($urandom), $urandom}; end
            5:       begin phase_ip = ip_pool[7];    phase_mac = {16'($urandom), $urandom}; end
            default: begin phase_ip = $urandom;      phase_mac = {16'($urandom), $urandom}; end
         endcase
         configure(phase_ip, phase_mac, phase == 4);
         span = (phase == 0) ? 20 : (phase == 1) ? 36 : POOL_SIZE;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (phase == 2 && i == 40) begin
               hold_requests <= hold_requests + 1;
            end
            offer_item(random_item(span));
         end
      end

      settle();
      if (tracker.mismatch_count == 0) begin
         $display("tb_arp_cache_learn_and_reply passed");
      end else begin
         $display("tb_arp_cache_learn_and_reply failed");
      end
      $finish;
   end

endmodule
